FILE: hw/rtl/speculation_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the speculation slot allocator
// Implication checks in the same cycle and in the next cycle, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPECULATION_SLOT_ALLOCATOR_ASSERT_SVH
`define SPECULATION_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent holds in the same cycle as the antecedent.
`define SSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define SSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Word types, codes and cell link types for the speculation slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int GID_W   = 5;
	localparam int CNT_W   = 32;
	localparam int ADDR_W  = 64;
	localparam int CFG_IDX_W = 2;

	// actions
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_SPEC    = 2'd1;
	localparam logic [1:0] ACT_DRAIN   = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BUSY     = 3'd1;
	localparam logic [2:0] ST_UNAVAIL  = 3'd2;
	localparam logic [2:0] ST_ILLOP    = 3'd3;
	localparam logic [2:0] ST_UNUSABLE = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SPECS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_ADDR = 2'd1;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] spec_id;
	} req_word_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [GID_W-1:0]  granted_id;
		logic [CNT_W-1:0]  written_count;
		logic [ADDR_W-1:0] fault_pc;
		logic [CNT_W-1:0]  busy_drops;
		logic [CNT_W-1:0]  unavail_drops;
	} rsp_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic       go;
		logic [1:0] action;
	} cell_cmd_t;

	// handed from one cell to the next, lowest id first
	typedef struct packed {
		logic             claimed;
		logic             busy;
		logic [GID_W-1:0] gid;
	} cell_link_t;

	// what a cell shows to the top level
	typedef struct packed {
		logic             in_use;
		logic             draining;
		logic             grant;
		logic [CNT_W-1:0] written;
	} cell_view_t;

endpackage

FILE: hw/rtl/ssa_cell.sv
// ----------------------------------------------------------------------------
// ssa_cell
// One speculation slot: in-use, draining and written count, plus its link
// in the lowest-free-slot search chain.
// ----------------------------------------------------------------------------
`include "speculation_slot_allocator_assert.svh"

module ssa_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssa_pkg::cell_cmd_t      cmd,
	input  logic                    sel,
	input  logic                    en,
	input  logic [ssa_pkg::GID_W-1:0] cell_id,
	input  ssa_pkg::cell_link_t     link_in,
	output ssa_pkg::cell_link_t     link_out,
	output ssa_pkg::cell_view_t     view
);
	import ssa_pkg::*;

	logic             in_use_q;
	logic             draining_q;
	logic [CNT_W-1:0] written_q;
	logic             free_here;
	logic             grant;

	// first searched free slot takes the grant
	assign free_here = en & ~in_use_q;
	assign grant     = cmd.go & (cmd.action == ACT_ALLOC) & free_here & ~link_in.claimed;

	always_comb begin
		link_out.claimed = link_in.claimed | free_here;
		link_out.busy    = link_in.busy | (en & in_use_q & draining_q);
		link_out.gid     = link_in.claimed ? link_in.gid : (free_here ? cell_id : '0);
	end

	assign view.in_use   = in_use_q;
	assign view.draining = draining_q;
	assign view.grant    = grant;
	assign view.written  = written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= 1'b0;
			draining_q <= 1'b0;
			written_q  <= '0;
		end else if (cmd.go) begin
			unique case (cmd.action)
				ACT_ALLOC: begin
					if (grant) begin
						in_use_q   <= 1'b1;
						draining_q <= 1'b0;
						written_q  <= '0;
					end
				end
				ACT_SPEC: begin
					if (sel && in_use_q && !draining_q) begin
						written_q <= written_q + CNT_W'(1);
					end
				end
				ACT_DRAIN: begin
					if (sel && in_use_q) begin
						draining_q <= 1'b1;
					end
				end
				ACT_RELEASE: begin
					if (sel && in_use_q) begin
						in_use_q   <= 1'b0;
						draining_q <= 1'b0;
						written_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`SSA_ASSERT_IMP(a_drain_needs_use, clk, arst_n, draining_q, in_use_q, "draining slot not in use")
	`SSA_ASSERT_NXT(a_grant_sets_use, clk, arst_n, grant, in_use_q && !draining_q && written_q == '0, "granted slot not set up")
	`SSA_ASSERT_IMP(a_free_slot_clear, clk, arst_n, !in_use_q, written_q == '0, "free slot holds a count")

endmodule

FILE: hw/rtl/speculation_slot_allocator.sv
// ----------------------------------------------------------------------------
// speculation_slot_allocator
// Speculation slot table built as a chain of slot cells; grants the lowest
// free slot id, counts written buffers, drains and releases slots.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall | action, spec_id
//  rsp     | out       | rsp_valid/rsp_stall | status, id, counts, fault_pc
//  cfg     | in        | cfg_valid/cfg_ready | index, 64-bit data
//
//  A request word is latched on acceptance and executed once the result
//  register is free or being emptied: every cell sees the command at once,
//  the free/busy search ripples through the cell chain, slot state and the
//  result register update on the same edge. One word per cycle sustained while
//  the result side keeps up, limited by the single execute stage.
//  A stalled result holds the execute stage; req_stall then stays high.
//  Reset clears every slot, both drop counters, num_specs to 1 and
//  fault_address to 0. No clearing pass: the table is usable straight away.
//  cfg_ready is always high; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`include "speculation_slot_allocator_assert.svh"

module speculation_slot_allocator #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  ssa_pkg::req_word_t            req_word,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ssa_pkg::rsp_word_t            rsp_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssa_pkg::ADDR_W-1:0]    cfg_data
);
	import ssa_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// configuration
	logic [4:0]        num_specs_q;
	logic [ADDR_W-1:0] fault_addr_q;

	// execute stage
	logic      op_v_s1;
	req_word_t op_s1;
	logic      go;

	// result
	logic      rsp_v_q;
	rsp_word_t rsp_q;
	rsp_word_t rsp_d;

	logic [CNT_W-1:0] busy_cnt_q;
	logic [CNT_W-1:0] unav_cnt_q;
	logic [CNT_W-1:0] busy_cnt_d;
	logic [CNT_W-1:0] unav_cnt_d;

	// cell chain
	cell_cmd_t      cmd;
	cell_link_t     link [MAX_SLOTS+1];
	cell_view_t     view [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] sel;
	logic [MAX_SLOTS-1:0] en;
	logic [MAX_SLOTS-1:0] use_v;
	logic [MAX_SLOTS-1:0] drain_v;
	logic [MAX_SLOTS-1:0] grant_v;

	logic             id_ok;
	logic [IDX_W-1:0] idx;
	logic             hit_use;
	logic             hit_drain;
	logic [7:0]       id_m1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_specs_q  <= 5'd1;
			fault_addr_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NUM_SPECS:  num_specs_q  <= cfg_data[4:0];
				CFG_FAULT_ADDR: fault_addr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage executes when the result register is free or being emptied
	assign go        = op_v_s1 & (~rsp_v_q | ~rsp_stall);
	assign req_stall = op_v_s1 & ~go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_v_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			op_v_s1 <= 1'b1;
		end else if (go) begin
			op_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1 <= req_word;
		end
	end

	assign cmd.go     = go;
	assign cmd.action = op_s1.action;

	assign link[0] = '{claimed: 1'b0, busy: 1'b0, gid: '0};

	// slot k holds id k+1
	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
		assign sel[k] = (op_s1.spec_id == 8'(k + 1));
		assign en[k]  = ({3'b000, num_specs_q} >= 8'(k + 1));

		ssa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.sel      (sel[k]),
			.en       (en[k]),
			.cell_id  (GID_W'(k + 1)),
			.link_in  (link[k]),
			.link_out (link[k+1]),
			.view     (view[k])
		);

		assign use_v[k]   = view[k].in_use;
		assign drain_v[k] = view[k].draining;
		assign grant_v[k] = view[k].grant;
	end

	assign id_ok     = (op_s1.spec_id != 8'd0) && (op_s1.spec_id <= 8'(MAX_SLOTS));
	assign id_m1     = op_s1.spec_id - 8'd1;
	assign idx       = id_m1[IDX_W-1:0];
	assign hit_use   = |(sel & use_v);
	assign hit_drain = |(sel & drain_v);

	always_comb begin
		rsp_d      = '0;
		busy_cnt_d = busy_cnt_q;
		unav_cnt_d = unav_cnt_q;
		unique case (op_s1.action)
			ACT_ALLOC: begin
				if (link[MAX_SLOTS].claimed) begin
					rsp_d.status     = ST_OK;
					rsp_d.granted_id = link[MAX_SLOTS].gid;
				end else if (link[MAX_SLOTS].busy) begin
					rsp_d.status = ST_BUSY;
					busy_cnt_d   = busy_cnt_q + CNT_W'(1);
				end else begin
					rsp_d.status = ST_UNAVAIL;
					unav_cnt_d   = unav_cnt_q + CNT_W'(1);
				end
			end
			ACT_SPEC: begin
				if (id_ok && hit_use && !hit_drain) begin
					rsp_d.written_count = view[idx].written + CNT_W'(1);
				end else begin
					rsp_d.status = ST_UNUSABLE;
				end
			end
			ACT_DRAIN: begin
				// absent slot: fine within num_specs, a fault above it
				if (!(id_ok && hit_use) && (op_s1.spec_id > {3'b000, num_specs_q})) begin
					rsp_d.status   = ST_ILLOP;
					rsp_d.fault_pc = fault_addr_q;
				end
			end
			ACT_RELEASE: begin
				if (!(id_ok && hit_use)) begin
					rsp_d.status = ST_UNUSABLE;
				end
			end
			default: begin
			end
		endcase
		rsp_d.busy_drops    = busy_cnt_d;
		rsp_d.unavail_drops = unav_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q    <= 1'b0;
			busy_cnt_q <= '0;
			unav_cnt_q <= '0;
		end else if (go) begin
			rsp_v_q    <= 1'b1;
			busy_cnt_q <= busy_cnt_d;
			unav_cnt_q <= unav_cnt_d;
		end else if (!rsp_stall) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp_word  = rsp_q;

	`SSA_ASSERT_IMP(a_single_grant, clk, arst_n, 1'b1, $onehot0(grant_v), "more than one slot granted")
	`SSA_ASSERT_NXT(a_go_gives_word, clk, arst_n, go, rsp_v_q, "executed word not presented")
	`SSA_ASSERT_IMP(a_grant_is_ok, clk, arst_n, rsp_v_q && rsp_q.granted_id != '0, rsp_q.status == ST_OK, "granted id with failing status")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: speculation slot allocator testbench
// Drives request words and register writes into the slot allocator, predicts
// every result word from a private copy of the slot table and checks each
// accepted result field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

	import ssa_pkg::*;

	localparam int SLOTS        = 16;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 153;
	// far beyond the length of any correct run
	localparam int LIMIT_CYCLES = 200000;
	// num_specs for each random phase: extremes, zero and lowering with slots held
	localparam int SPEC_PLAN [PHASES] = '{16, 0, 5, 1, 16, 3, 12, 2, 16, 7};

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the slot table, queues one predicted result word per
	// accepted request word and compares results in order.
	// ------------------------------------------------------------------------
	class slot_scoreboard;
		logic [GID_W-1:0]  num_specs;
		logic [ADDR_W-1:0] fault_addr;
		bit                in_use   [SLOTS];
		bit                draining [SLOTS];
		logic [CNT_W-1:0]  written  [SLOTS];
		logic [CNT_W-1:0]  busy_drops;
		logic [CNT_W-1:0]  unavail_drops;
		rsp_word_t         outcome_q[$];
		int                errors;
		int                words_checked;
		int                status_seen [5];

		function new();
			num_specs     = GID_W'(1);
			fault_addr    = '0;
			busy_drops    = '0;
			unavail_drops = '0;
			foreach (in_use[i]) begin
				in_use[i]   = 1'b0;
				draining[i] = 1'b0;
				written[i]  = '0;
			end
			foreach (status_seen[i])
				status_seen[i] = 0;
			errors        = 0;
			words_checked = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
			if (idx == CFG_NUM_SPECS)
				num_specs = data[GID_W-1:0];
			else if (idx == CFG_FAULT_ADDR)
				fault_addr = data;
		endfunction

		// applies one request to the mirrored table, returns the result word
		function rsp_word_t slot_table_outcome(req_word_t w);
			rsp_word_t o;
			int        slot;
			int        bound;
			int        n;
			bit        saw_busy;
			bit        granted;
			o        = '0;
			o.status = ST_OK;
			slot     = (w.spec_id >= 1 && w.spec_id <= SLOTS) ? int'(w.spec_id) - 1 : -1;
			case (w.action)
			ACT_ALLOC: begin
				bound    = (num_specs > SLOTS) ? SLOTS : int'(num_specs);
				saw_busy = 1'b0;
				granted  = 1'b0;
				// lowest free id wins; draining slots only mark the search busy
				for (n = 1; n <= bound && !granted; n++) begin
					if (!in_use[n-1]) begin
						in_use[n-1]   = 1'b1;
						draining[n-1] = 1'b0;
						written[n-1]  = '0;
						o.granted_id  = GID_W'(n);
						granted       = 1'b1;
					end else if (draining[n-1]) begin
						saw_busy = 1'b1;
					end
				end
				if (!granted) begin
					if (saw_busy) begin
						busy_drops = busy_drops + 1'b1;
						o.status   = ST_BUSY;
					end else begin
						unavail_drops = unavail_drops + 1'b1;
						o.status      = ST_UNAVAIL;
					end
				end
			end
			ACT_SPEC: begin
				if (slot >= 0 && in_use[slot] && !draining[slot]) begin
					written[slot]   = written[slot] + 1'b1;
					o.written_count = written[slot];
				end else begin
					o.status = ST_UNUSABLE;
				end
			end
			ACT_DRAIN: begin
				// an absent slot is harmless within num_specs, a fault beyond it
				if (slot >= 0 && in_use[slot]) begin
					draining[slot] = 1'b1;
				end else if (w.spec_id > num_specs) begin
					o.status   = ST_ILLOP;
					o.fault_pc = fault_addr;
				end
			end
			ACT_RELEASE: begin
				if (slot >= 0 && in_use[slot]) begin
					in_use[slot]   = 1'b0;
					draining[slot] = 1'b0;
					written[slot]  = '0;
				end else begin
					o.status = ST_UNUSABLE;
				end
			end
			endcase
			o.busy_drops    = busy_drops;
			o.unavail_drops = unavail_drops;
			return o;
		endfunction

		function void note_request(req_word_t w);
			outcome_q.push_back(slot_table_outcome(w));
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(rsp_word_t got);
			rsp_word_t want;
			if (outcome_q.size() == 0) begin
				$display("%0t: result word with no request outstanding: %p", $time, got);
				errors++;
				return;
			end
			want = outcome_q.pop_front();
			words_checked++;
			status_seen[int'(want.status)]++;
			field_check("status",        want.status,        got.status);
			field_check("granted_id",    want.granted_id,    got.granted_id);
			field_check("written_count", want.written_count, got.written_count);
			field_check("fault_pc",      want.fault_pc,      got.fault_pc);
			field_check("busy_drops",    want.busy_drops,    got.busy_drops);
			field_check("unavail_drops", want.unavail_drops, got.unavail_drops);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_word_t            req_word;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_word_t            rsp_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	speculation_slot_allocator #(
		.MAX_SLOTS (SLOTS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	slot_scoreboard sb = new();

	// calm: no idling on either side; hold_request: ask the receiver for one
	// long stall so that the block backs up into req_stall
	bit calm         = 1'b0;
	bit hold_request = 1'b0;
	int items_sent   = 0;
	int settings_used = 0;
	int input_stalls = 0;
	int cycles       = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every input is driven with NBAs at the edge, so a read right after the
	// edge sees the values the block sampled there. Request noted before the
	// result is checked, so ordering holds even for an unregistered path.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (req_valid && !req_stall)
				sb.note_request(req_word);
			if (rsp_valid && !rsp_stall)
				sb.check_outcome(rsp_word);
			if (req_valid && req_stall)
				input_stalls++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycles,
				items_sent - sb.words_checked);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: stalls at random about 27% of cycles, none while calm,
	// and one long hold-off counted here on request.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 64;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 27);
			end
		end
	end

	// Offers one request word; idles first at random, then holds the word
	// until it is taken.
	task automatic send_request(input logic [1:0] act, input logic [7:0] id);
		while (!calm && $urandom_range(99) < 27) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_word  <= '{action: act, spec_id: id};
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// Waits until every request has had its result word back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.words_checked < items_sent)
			@(posedge clk);
	endtask

	// Writes both registers back to back; only called with the block idle.
	task automatic set_config(input logic [GID_W-1:0] n, input logic [ADDR_W-1:0] addr);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_NUM_SPECS;
		cfg_data  <= ADDR_W'(n);
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(CFG_NUM_SPECS, ADDR_W'(n));
		cfg_index <= CFG_FAULT_ADDR;
		cfg_data  <= addr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(CFG_FAULT_ADDR, addr);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [ADDR_W-1:0] addr;
		logic [1:0]        act;
		logic [7:0]        id;
		int                r;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_word  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// -- directed: two slots, fault address all ones --------------------
		set_config(GID_W'(2), '1);
		send_request(ACT_ALLOC,   8'd0);    // grants 1
		send_request(ACT_ALLOC,   8'd255);  // grants 2, id ignored
		send_request(ACT_ALLOC,   8'd0);    // table full, none draining
		send_request(ACT_SPEC,    8'd1);
		send_request(ACT_SPEC,    8'd1);
		send_request(ACT_SPEC,    8'd2);
		send_request(ACT_SPEC,    8'd0);    // no such slot
		send_request(ACT_SPEC,    8'd255);
		send_request(ACT_SPEC,    8'd17);   // just past the table
		send_request(ACT_DRAIN,   8'd1);
		send_request(ACT_SPEC,    8'd1);    // draining, not usable
		send_request(ACT_ALLOC,   8'd0);    // refused with a draining slot
		send_request(ACT_DRAIN,   8'd3);    // absent and beyond num_specs
		send_request(ACT_DRAIN,   8'd0);    // absent but within num_specs
		send_request(ACT_DRAIN,   8'd255);
		send_request(ACT_DRAIN,   8'd16);
		send_request(ACT_RELEASE, 8'd1);
		send_request(ACT_RELEASE, 8'd1);    // already free
		send_request(ACT_RELEASE, 8'd0);
		send_request(ACT_RELEASE, 8'd200);
		send_request(ACT_ALLOC,   8'd0);    // lowest free id again
		send_request(ACT_DRAIN,   8'd2);
		send_request(ACT_ALLOC,   8'd0);    // busy drop via the higher slot
		send_request(ACT_RELEASE, 8'd2);
		send_request(ACT_RELEASE, 8'd1);
		wait_idle();

		// -- random phases -------------------------------------------------
		// Slots left in use carry over, so lowering num_specs leaves slots
		// above it that stay addressable.
		for (int phase = 0; phase < PHASES; phase++) begin
			addr = (phase == 0) ? '0 : (phase == 1) ? '1 : {$urandom, $urandom};
			set_config(GID_W'(SPEC_PLAN[phase]), addr);
			// one phase runs with no idling, and holds the result side off
			calm = (phase == 4);
			if (phase == 4)
				hold_request = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(99);
				if (r < 30)
					act = ACT_ALLOC;
				else if (r < 58)
					act = ACT_SPEC;
				else if (r < 72)
					act = ACT_DRAIN;
				else
					act = ACT_RELEASE;
				// mostly live ids so speculate/release find slots in use
				r = $urandom_range(99);
				if (r < 8)
					id = 8'($urandom_range(255));
				else if (r < 12)
					id = '0;
				else if (r < 40)
					id = 8'($urandom_range(SLOTS + 1, 1));
				else
					id = 8'($urandom_range(SPEC_PLAN[phase] + 1, 1));
				send_request(act, id);
			end
			calm = 1'b0;
			wait_idle();
		end

		// results are registered; the spare cycles below catch any stray words
		repeat (8) @(posedge clk);
		$display("Run covered %0d request words over %0d register settings; input held %0d cycles",
			items_sent, settings_used, input_stalls);
		$display("Outcomes: ok %0d, busy drop %0d, unavailable drop %0d, illegal op %0d, unusable %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_BUSY], sb.status_seen[ST_UNAVAIL],
			sb.status_seen[ST_ILLOP], sb.status_seen[ST_UNUSABLE]);
		if (sb.errors == 0 && sb.outcome_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_cell.sv
hw/rtl/speculation_slot_allocator.sv
tb/tb.sv
